@@ rtl/utf8d_pkg.sv @@
// shared types and constants of the utf-8 decoder
package utf8d_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned CP_W   = 21;
	localparam int unsigned LEFT_W = 2;
	localparam int unsigned TDATA_OUT_W = 24;

	// lead byte classes: mask and match patterns
	localparam logic [BYTE_W-1:0] ASCII_MASK  = 8'h80;
	localparam logic [BYTE_W-1:0] ASCII_MATCH = 8'h00;
	localparam logic [BYTE_W-1:0] LEAD2_MASK  = 8'hE0;
	localparam logic [BYTE_W-1:0] LEAD2_MATCH = 8'hC0;
	localparam logic [BYTE_W-1:0] LEAD3_MASK  = 8'hF0;
	localparam logic [BYTE_W-1:0] LEAD3_MATCH = 8'hE0;
	localparam logic [BYTE_W-1:0] LEAD4_MASK  = 8'hF8;
	localparam logic [BYTE_W-1:0] LEAD4_MATCH = 8'hF0;

	// payload masks
	localparam logic [BYTE_W-1:0] ASCII_PAY = 8'h7F;
	localparam logic [BYTE_W-1:0] LEAD2_PAY = 8'h1F;
	localparam logic [BYTE_W-1:0] LEAD3_PAY = 8'h0F;
	localparam logic [BYTE_W-1:0] LEAD4_PAY = 8'h07;
	localparam int unsigned CONT_BITS = 6;

	// continuation bytes still due
	localparam logic [LEFT_W-1:0] LEFT_IDLE = 2'd0;
	localparam logic [LEFT_W-1:0] LEFT_ONE  = 2'd1;
	localparam logic [LEFT_W-1:0] LEFT_TWO  = 2'd2;
	localparam logic [LEFT_W-1:0] LEFT_THREE = 2'd3;

	// one decode result toward the output register
	typedef struct packed {
		logic            vld;
		logic [CP_W-1:0] cp;
		logic            err;
	} res_t;

endpackage

@@ rtl/utf8d_in_stage.sv @@
// input register stage: holds one byte until the decoder takes it
module utf8d_in_stage (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	input  logic [utf8d_pkg::BYTE_W-1:0]   s_axis_tdata,
	input  logic                           adv,
	output logic                           fire,
	output logic [utf8d_pkg::BYTE_W-1:0]   byte_s1
);
	import utf8d_pkg::*;

	logic v_s1;
	logic take;

	assign s_axis_tready = !v_s1 || adv;
	assign take          = s_axis_tvalid && s_axis_tready;
	assign fire          = v_s1 && adv;

	// valid flag of the stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (take) begin
			v_s1 <= 1'b1;
		end else if (fire) begin
			v_s1 <= 1'b0;
		end
	end

	// byte payload
	always_ff @(posedge clk) begin
		if (take) begin
			byte_s1 <= s_axis_tdata;
		end
	end

endmodule

@@ rtl/utf8d_decode.sv @@
// decode step: partial code point, count of continuation bytes, result logic
module utf8d_decode (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         fire,
	input  logic [utf8d_pkg::BYTE_W-1:0] in_byte,
	output utf8d_pkg::res_t              res
);
	import utf8d_pkg::*;

	logic [CP_W-1:0]   partial_q;
	logic [LEFT_W-1:0] left_q;
	logic [CP_W-1:0]   partial_d;
	logic [LEFT_W-1:0] left_d;
	logic [CP_W-1:0]   shifted;

	assign shifted = {partial_q[CP_W-CONT_BITS-1:0], in_byte[CONT_BITS-1:0]};

	// next state and result for the byte in the input stage
	always_comb begin
		partial_d = partial_q;
		left_d    = left_q;
		res.vld   = 1'b0;
		res.cp    = '0;
		res.err   = 1'b0;
		if (fire) begin
			if (left_q != LEFT_IDLE) begin
				// continuation byte, top bits not checked
				left_d = left_q - LEFT_ONE;
				if (left_q == LEFT_ONE) begin
					res.vld   = 1'b1;
					res.cp    = shifted;
					partial_d = '0;
				end else begin
					partial_d = shifted;
				end
			end else if ((in_byte & ASCII_MASK) == ASCII_MATCH) begin
				res.vld = 1'b1;
				res.cp  = CP_W'(in_byte & ASCII_PAY);
			end else if ((in_byte & LEAD2_MASK) == LEAD2_MATCH) begin
				partial_d = CP_W'(in_byte & LEAD2_PAY);
				left_d    = LEFT_ONE;
			end else if ((in_byte & LEAD3_MASK) == LEAD3_MATCH) begin
				partial_d = CP_W'(in_byte & LEAD3_PAY);
				left_d    = LEFT_TWO;
			end else if ((in_byte & LEAD4_MASK) == LEAD4_MATCH) begin
				partial_d = CP_W'(in_byte & LEAD4_PAY);
				left_d    = LEFT_THREE;
			end else begin
				// stray continuation or 11111xxx where a lead byte belongs
				partial_d = '0;
				res.vld   = 1'b1;
				res.err   = 1'b1;
			end
		end
	end

	// decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			partial_q <= '0;
			left_q    <= LEFT_IDLE;
		end else begin
			partial_q <= partial_d;
			left_q    <= left_d;
		end
	end

	// ascii byte while idle gives a clean result at once
	a_ascii: assert property (@(posedge clk) disable iff (!arst_n)
		fire && (left_q == LEFT_IDLE) && !in_byte[BYTE_W-1] |-> res.vld && !res.err)
		else $error("ascii byte gave no result");

	// an error result leaves the decoder idle
	a_err_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res.vld && res.err |=> left_q == LEFT_IDLE)
		else $error("decoder not idle after error");

	// a continuation byte counts down by one
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		fire && (left_q != LEFT_IDLE) |=> left_q == $past(left_q) - LEFT_ONE)
		else $error("continuation count slipped");

	// an error result carries a zero code point
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res.err |-> res.vld && (res.cp == '0))
		else $error("error result with nonzero code point");

endmodule

@@ rtl/utf8d_out_reg.sv @@
// result register toward the output stream
module utf8d_out_reg (
	input  logic                              clk,
	input  logic                              arst_n,
	input  utf8d_pkg::res_t                   res,
	output logic                              adv,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [utf8d_pkg::TDATA_OUT_W-1:0] m_axis_tdata,
	output logic                              m_axis_tuser
);
	import utf8d_pkg::*;

	logic            out_v_q;
	logic [CP_W-1:0] cp_q;
	logic            err_q;

	assign adv           = !out_v_q || m_axis_tready;
	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = {{(TDATA_OUT_W-CP_W){1'b0}}, cp_q};
	assign m_axis_tuser  = err_q;

	// valid flag of the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (res.vld) begin
			out_v_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_v_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (res.vld) begin
			cp_q  <= res.cp;
			err_q <= res.err;
		end
	end

endmodule

@@ rtl/utf8_to_code_point_decoder_core.sv @@
// UTF-8 decoder: one byte a beat in, one code point per complete sequence out
// The decoder takes one byte per beat on the s_axis side and gives one
// code point per beat on the m_axis side each time a one- to four-byte
// sequence completes; a lead byte of the form 10xxxxxx or 11111xxx gives a
// result with tuser set and a zero code point. Continuation bytes are taken
// without checking their top two bits, and overlong forms, surrogates and
// values above 0x10FFFF pass through as their 21 payload bits. Throughput is
// one byte per clock while m_axis_tready keeps the result register free;
// the input register takes the byte, the decode step writes its result
// into the result register, and the result beat leaves from there. While a
// result waits, the input register still takes one more byte.
module utf8_to_code_point_decoder_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [utf8d_pkg::BYTE_W-1:0]      s_axis_tdata,  // [7:0] in_byte
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [utf8d_pkg::TDATA_OUT_W-1:0] m_axis_tdata,  // [20:0] code_point, rest zero
	output logic                              m_axis_tuser   // [0] error
);
	import utf8d_pkg::*;

	logic              adv;
	logic              fire;
	logic [BYTE_W-1:0] byte_s1;
	res_t              res;

	// input register
	utf8d_in_stage u_in (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.adv           (adv),
		.fire          (fire),
		.byte_s1       (byte_s1)
	);

	// decode step and sequence state
	utf8d_decode u_dec (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (fire),
		.in_byte (byte_s1),
		.res     (res)
	);

	// result register
	utf8d_out_reg u_out (
		.clk           (clk),
		.arst_n        (arst_n),
		.res           (res),
		.adv           (adv),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

endmodule

@@ dv/utf8_to_code_point_decoder_core_tb.sv @@
// testbench of the utf-8 decoder core: directed table, random byte streams, scoreboard
module utf8_to_code_point_decoder_core_tb;
	import utf8d_pkg::*;

	localparam logic ERR_NONE     = 1'b0;
	localparam logic ERR_BAD_LEAD = 1'b1;
	localparam int   RAND_BYTES   = 1700;
	localparam int   STEADY_FIRST = 700;
	localparam int   STEADY_LAST  = 1000;

	typedef struct {
		logic [BYTE_W-1:0] in_byte;
		bit                typed;
		logic [CP_W-1:0]   cp;
		logic              err;
	} stim_row_t;

	typedef struct {
		logic [CP_W-1:0] cp;
		logic            err;
	} cp_beat_t;

	logic                   clk;
	logic                   arst_n;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	logic [BYTE_W-1:0]      s_axis_tdata;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	logic [TDATA_OUT_W-1:0] m_axis_tdata;
	logic                   m_axis_tuser;

	// decoder state as predicted
	logic [CP_W-1:0]   pend_cp;
	logic [LEFT_W-1:0] cont_due;

	cp_beat_t pending_cps[$];
	bit       steady;
	int       mismatches;
	int       bytes_sent;
	int       cps_seen;
	int       bad_leads_seen;
	int       holdoffs;
	int       seq_by_len[1:4];

	// directed bytes: extremes, bad leads, each sequence length, unchecked continuations
	stim_row_t dir_rows [0:24] = '{
		'{8'h00, 1'b1, 21'h000000, ERR_NONE},
		'{8'h7F, 1'b1, 21'h00007F, ERR_NONE},
		'{8'h80, 1'b1, 21'h000000, ERR_BAD_LEAD},
		'{8'hF8, 1'b1, 21'h000000, ERR_BAD_LEAD},
		'{8'hFF, 1'b1, 21'h000000, ERR_BAD_LEAD},
		'{8'hC0, 1'b0, 21'h000000, ERR_NONE},
		'{8'h80, 1'b1, 21'h000000, ERR_NONE},
		'{8'hDF, 1'b0, 21'h000000, ERR_NONE},
		'{8'hBF, 1'b1, 21'h0007FF, ERR_NONE},
		'{8'hEF, 1'b0, 21'h000000, ERR_NONE},
		'{8'hBF, 1'b0, 21'h000000, ERR_NONE},
		'{8'hBF, 1'b1, 21'h00FFFF, ERR_NONE},
		'{8'hED, 1'b0, 21'h000000, ERR_NONE},
		'{8'hA0, 1'b0, 21'h000000, ERR_NONE},
		'{8'h80, 1'b0, 21'h000000, ERR_NONE},
		'{8'hF0, 1'b0, 21'h000000, ERR_NONE},
		'{8'h90, 1'b0, 21'h000000, ERR_NONE},
		'{8'h80, 1'b0, 21'h000000, ERR_NONE},
		'{8'h80, 1'b0, 21'h000000, ERR_NONE},
		'{8'hF7, 1'b0, 21'h000000, ERR_NONE},
		'{8'hBF, 1'b0, 21'h000000, ERR_NONE},
		'{8'hBF, 1'b0, 21'h000000, ERR_NONE},
		'{8'hBF, 1'b1, 21'h1FFFFF, ERR_NONE},
		'{8'hC2, 1'b0, 21'h000000, ERR_NONE},
		'{8'h41, 1'b0, 21'h000000, ERR_NONE}
	};

	utf8_to_code_point_decoder_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	// clock, period 4
	initial clk = 1'b0;
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// decode one byte into the predicted state, returns 1 when a result comes out
	function automatic bit decode_byte(input logic [BYTE_W-1:0] b, output logic [CP_W-1:0] cp,
			output logic err);
		cp  = '0;
		err = ERR_NONE;
		if (cont_due != LEFT_IDLE) begin
			pend_cp  = {pend_cp[CP_W-CONT_BITS-1:0], b[CONT_BITS-1:0]};
			cont_due = cont_due - 1'b1;
			if (cont_due != LEFT_IDLE)
				return 1'b0;
			cp      = pend_cp;
			pend_cp = '0;
			return 1'b1;
		end
		if ((b & ASCII_MASK) == ASCII_MATCH) begin
			cp = CP_W'(b & ASCII_PAY);
			return 1'b1;
		end
		if ((b & LEAD2_MASK) == LEAD2_MATCH) begin
			pend_cp  = CP_W'(b & LEAD2_PAY);
			cont_due = LEFT_ONE;
			return 1'b0;
		end
		if ((b & LEAD3_MASK) == LEAD3_MATCH) begin
			pend_cp  = CP_W'(b & LEAD3_PAY);
			cont_due = LEFT_TWO;
			return 1'b0;
		end
		if ((b & LEAD4_MASK) == LEAD4_MATCH) begin
			pend_cp  = CP_W'(b & LEAD4_PAY);
			cont_due = LEFT_THREE;
			return 1'b0;
		end
		// neither a lead byte nor ascii while idle
		pend_cp = '0;
		err     = ERR_BAD_LEAD;
		return 1'b1;
	endfunction

	// send one byte beat, with random idle cycles in front of it outside the steady phase
	task automatic send_byte(input logic [BYTE_W-1:0] b, input bit typed = 1'b0,
			input logic [CP_W-1:0] tcp = '0, input logic terr = ERR_NONE);
		cp_beat_t beat;
		bit       got;
		@(negedge clk);
		while (!steady && $urandom_range(99) < 22) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		do @(posedge clk); while (!s_axis_tready);
		bytes_sent++;
		got = decode_byte(b, beat.cp, beat.err);
		if (got) begin
			if (typed) begin
				beat.cp  = tcp;
				beat.err = terr;
			end
			pending_cps = {pending_cps, beat};
		end
	endtask

	// hold the sender off until every expected code point has come out
	task automatic hold_off_until_drained();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (pending_cps.size() != 0)
			@(negedge clk);
		holdoffs++;
	endtask

	// one random unit: mostly well-formed sequences, some noise and cut sequences
	task automatic send_random_unit();
		int                r;
		int                len;
		int                n_cont;
		logic [BYTE_W-1:0] b;
		r = $urandom_range(99);
		if (r < 12) begin
			send_byte(8'($urandom_range(255)));
		end else if (r < 18) begin
			// bad lead byte: 10xxxxxx or 11111xxx
			b = $urandom_range(1) ? {2'b10, 6'($urandom)} : {5'b11111, 3'($urandom)};
			send_byte(b);
		end else begin
			len    = $urandom_range(1, 4);
			n_cont = len - 1;
			// a cut sequence lets the next lead byte be taken as a continuation
			if (r < 24 && len > 1)
				n_cont = $urandom_range(0, len - 2);
			case (len)
				1: b = {1'b0, 7'($urandom)};
				2: b = {3'b110, 5'($urandom)};
				3: b = {4'b1110, 4'($urandom)};
				default: b = {5'b11110, 3'($urandom)};
			endcase
			seq_by_len[len]++;
			send_byte(b);
			for (int i = 0; i < n_cont; i++) begin
				if ($urandom_range(15) == 0)
					send_byte(8'($urandom));
				else
					send_byte({2'b10, 6'($urandom)});
			end
		end
	endtask

	// receiver stalls
	always @(negedge clk)
		m_axis_tready <= steady || ($urandom_range(99) >= 22);

	// compare each output beat with the oldest expectation
	always @(posedge clk) begin
		cp_beat_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_cps.size() == 0) begin
				if (mismatches < 10)
					$display("unexpected beat: code_point %h error %b",
						m_axis_tdata[CP_W-1:0], m_axis_tuser);
				mismatches++;
			end else begin
				want = pending_cps.pop_front();
				if (m_axis_tdata !== TDATA_OUT_W'(want.cp) || m_axis_tuser !== want.err) begin
					if (mismatches < 10)
						$display("mismatch: want tdata %h error %b, got tdata %h error %b",
							TDATA_OUT_W'(want.cp), want.err, m_axis_tdata, m_axis_tuser);
					mismatches++;
				end
				if (m_axis_tuser === ERR_BAD_LEAD)
					bad_leads_seen++;
				else
					cps_seen++;
			end
		end
	end

	// run limit
	initial begin
		#800000;
		$display("Verification failed");
		$finish;
	end

	// stimulus and end of run
	initial begin
		int rand_start;
		pend_cp        = '0;
		cont_due       = LEFT_IDLE;
		steady         = 1'b0;
		mismatches     = 0;
		bytes_sent     = 0;
		cps_seen       = 0;
		bad_leads_seen = 0;
		holdoffs       = 0;
		seq_by_len     = '{0, 0, 0, 0};
		arst_n         = 1'b0;
		s_axis_tvalid  = 1'b0;
		s_axis_tdata   = '0;
		m_axis_tready  = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed table
		foreach (dir_rows[i])
			send_byte(dir_rows[i].in_byte, dir_rows[i].typed, dir_rows[i].cp, dir_rows[i].err);
		hold_off_until_drained();

		// random byte stream
		rand_start = bytes_sent;
		while (bytes_sent - rand_start < RAND_BYTES) begin
			steady = (bytes_sent - rand_start >= STEADY_FIRST) &&
				(bytes_sent - rand_start < STEADY_LAST);
			send_random_unit();
			if ($urandom_range(149) == 0)
				hold_off_until_drained();
		end
		steady = 1'b0;
		@(negedge clk);
		s_axis_tvalid <= 1'b0;

		// wait for the tail, then let any stray beat show up
		while (pending_cps.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (pending_cps.size() != 0)
			mismatches++;

		$display("sent %0d bytes; got %0d code points and %0d bad-lead results",
			bytes_sent, cps_seen, bad_leads_seen);
		$display("random sequences by length 1/2/3/4: %0d/%0d/%0d/%0d, %0d full drains, %0d mismatches",
			seq_by_len[1], seq_by_len[2], seq_by_len[3], seq_by_len[4], holdoffs, mismatches);
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

@@ utf8_to_code_point_decoder_core.f @@
rtl/utf8d_pkg.sv
rtl/utf8d_in_stage.sv
rtl/utf8d_decode.sv
rtl/utf8d_out_reg.sv
rtl/utf8_to_code_point_decoder_core.sv
dv/utf8_to_code_point_decoder_core_tb.sv
